@@ hdl/cba_pkg.sv @@
// types and constants shared by the contiguous block allocator modules
package cba_pkg;

   // field widths
   localparam int OP_W    = 2;
   localparam int DESC_W  = 8;
   localparam int SIZE_W  = 14;
   localparam int STAT_W  = 2;
   localparam int START_W = 10;
   localparam int COUNT_W = 11;
   localparam int NEED_W  = 12;

   // operation codes
   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_GET    = 2'd1;
   localparam logic [OP_W-1:0] OP_DEL    = 2'd2;
   localparam logic [OP_W-1:0] OP_DEFRAG = 2'd3;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOSPACE  = 2'd1;
   localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;

   // cell sizing: 8 kB per cell, at least two cells per allocation
   localparam int                KB_SHIFT  = 3;
   localparam logic [SIZE_W:0]   KB_ROUND  = 15'd7;
   localparam logic [NEED_W-1:0] MIN_CELLS = 12'd2;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [DESC_W-1:0] descriptor;
      logic [SIZE_W-1:0] size_kb;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [START_W-1:0] start_index;
      logic [COUNT_W-1:0] block_count;
   } rsp_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_FILL,
      S_REPLY
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic start;
      logic scan;
      logic fill;
      logic load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic reject;
      logic scan_done;
      logic go_fill;
      logic fill_done;
   } stat_type;

endpackage

@@ hdl/cba_ctrl.sv @@
// controller state machine of the contiguous block allocator
module cba_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cba_pkg::stat_type stat,
   input  logic              rsp_busy,
   output cba_pkg::cmd_type  cmd
);
   import cba_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register, clearing pass first after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (stat.fill_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (stat.reject) begin
               state_in = S_REPLY;
            end else if (stat.scan_done) begin
               state_in = stat.go_fill ? S_FILL : S_REPLY;
            end
         end
         S_FILL: begin
            if (stat.fill_done) state_in = S_REPLY;
         end
         S_REPLY: begin
            if (!rsp_busy) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.fill = 1'b1;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid;
         end
         S_SCAN: begin
            cmd.scan = !stat.reject;
         end
         S_FILL: begin
            cmd.fill = 1'b1;
         end
         S_REPLY: begin
            cmd.load_rsp = !rsp_busy;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

@@ hdl/cba_dpath.sv @@
// datapath: cell owner memory, scan pipeline, fill sweep and result register
module cba_dpath #(
   parameter int CELLS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  cba_pkg::req_type  req_item,
   input  cba_pkg::cmd_type  cmd,
   output cba_pkg::stat_type stat,
   output logic              rsp_busy,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cba_pkg::rsp_type  rsp_item
);
   import cba_pkg::*;

   localparam int AW   = $clog2(CELLS);
   localparam int CW   = $clog2(CELLS) + 1;
   localparam int CMPW = (CW > NEED_W) ? CW : NEED_W;
   localparam logic [CW-1:0]   CELLS_C = CW'(CELLS);
   localparam logic [CW-1:0]   LAST_C  = CW'(CELLS - 1);
   localparam logic [AW-1:0]   LAST_A  = AW'(CELLS - 1);
   localparam logic [CMPW-1:0] CELLS_M = CMPW'(CELLS);

   // cell owner store
   logic [DESC_W-1:0] mem [CELLS];
   logic [DESC_W-1:0] rd_data_ff;

   // latched item
   logic [OP_W-1:0]   op_ff;
   logic [DESC_W-1:0] desc_ff;
   logic [NEED_W-1:0] need_ff;

   // scan pipeline
   logic [CW-1:0] issue_ff, issue_in;
   logic          proc_vld_ff, proc_vld_in;
   logic [AW-1:0] proc_addr_ff;

   // scan results
   logic [CW-1:0] run_ff, wr_ff, start_ff, count_ff;
   logic          hit_ff, found_ff;

   // fill sweep
   logic [CW-1:0]     fill_addr_ff, fill_last_ff;
   logic [DESC_W-1:0] fill_data_ff;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_item_ff, rsp_item_in;

   // combinational helpers
   logic [SIZE_W:0]   kb_round;
   logic [NEED_W-1:0] need_raw, need_in;
   logic              issue_act, proc_act, cell_free, cell_mine;
   logic              add_hit, get_end, proc_last, dfg_wr;
   logic [CMPW-1:0]   run_next, add_start;
   logic [CW-1:0]     wr_next;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [DESC_W-1:0] wr_data;

   // cell count from size: round up to whole cells, at least two
   always_comb begin
      kb_round = {1'b0, req_item.size_kb} + KB_ROUND;
      need_raw = NEED_W'(kb_round >> KB_SHIFT);
      need_in  = (need_raw < MIN_CELLS) ? MIN_CELLS : need_raw;
   end

   // latch the item
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff   <= req_item.operation;
         desc_ff <= req_item.descriptor;
         need_ff <= need_in;
      end
   end

   // read issue and process stage control
   always_comb begin
      issue_act   = cmd.scan && (issue_ff < CELLS_C);
      proc_act    = cmd.scan && proc_vld_ff;
      issue_in    = issue_ff;
      proc_vld_in = issue_act;
      if (cmd.start) begin
         issue_in    = '0;
         proc_vld_in = 1'b0;
      end else if (issue_act) begin
         issue_in = issue_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff    <= '0;
         proc_vld_ff <= 1'b0;
      end else begin
         issue_ff    <= issue_in;
         proc_vld_ff <= proc_vld_in;
      end
      proc_addr_ff <= issue_ff[AW-1:0];
   end

   // per-cell decisions on the registered read data
   always_comb begin
      cell_free = (rd_data_ff == '0);
      cell_mine = (rd_data_ff == desc_ff);
      run_next  = CMPW'(run_ff) + 1'b1;
      add_start = CMPW'(proc_addr_ff) + 1'b1 - CMPW'(need_ff);
      add_hit   = proc_act && (op_ff == OP_ADD) && cell_free
                  && (run_next == CMPW'(need_ff));
      get_end   = proc_act && (op_ff == OP_GET) && found_ff && !cell_mine;
      proc_last = proc_act && (proc_addr_ff == LAST_A);
      dfg_wr    = proc_act && (op_ff == OP_DEFRAG) && !cell_free;
      wr_next   = wr_ff + CW'(dfg_wr);
   end

   // status to the controller
   always_comb begin
      stat.reject    = ((op_ff == OP_ADD)
                        && ((desc_ff == '0) || (CMPW'(need_ff) > CELLS_M)))
                       || ((op_ff == OP_GET) && (desc_ff == '0));
      stat.scan_done = add_hit || get_end || proc_last;
      stat.go_fill   = add_hit || (op_ff == OP_DEFRAG);
      stat.fill_done = (fill_addr_ff == fill_last_ff) || (fill_addr_ff == CELLS_C);
   end

   // scan bookkeeping
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         run_ff   <= '0;
         wr_ff    <= '0;
         hit_ff   <= 1'b0;
         found_ff <= 1'b0;
         start_ff <= '0;
         count_ff <= '0;
      end else if (proc_act) begin
         case (op_ff)
            OP_ADD: begin
               run_ff <= cell_free ? CW'(run_next) : '0;
               if (add_hit) begin
                  hit_ff   <= 1'b1;
                  start_ff <= CW'(add_start);
               end
            end
            OP_GET: begin
               if (!found_ff && cell_mine) begin
                  found_ff <= 1'b1;
                  start_ff <= CW'(proc_addr_ff);
                  count_ff <= CW'(1);
               end else if (found_ff && cell_mine) begin
                  count_ff <= count_ff + 1'b1;
               end
            end
            OP_DEFRAG: begin
               wr_ff <= wr_next;
            end
            default: begin
               run_ff <= run_ff;
            end
         endcase
      end
   end

   // fill sweep range: whole store after reset, run for add, tail for defrag
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_addr_ff <= '0;
         fill_last_ff <= LAST_C;
         fill_data_ff <= '0;
      end else if (cmd.fill) begin
         if (!stat.fill_done) fill_addr_ff <= fill_addr_ff + 1'b1;
      end else if (add_hit) begin
         fill_addr_ff <= CW'(add_start);
         fill_last_ff <= CW'(proc_addr_ff);
         fill_data_ff <= desc_ff;
      end else if (proc_last && (op_ff == OP_DEFRAG)) begin
         fill_addr_ff <= wr_next;
         fill_last_ff <= LAST_C;
         fill_data_ff <= '0;
      end
   end

   // single write port select
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = proc_addr_ff;
      wr_data = '0;
      if (cmd.fill && (fill_addr_ff < CELLS_C)) begin
         wr_en   = 1'b1;
         wr_addr = fill_addr_ff[AW-1:0];
         wr_data = fill_data_ff;
      end else if (proc_act && (op_ff == OP_DEL) && cell_mine) begin
         wr_en   = 1'b1;
         wr_addr = proc_addr_ff;
         wr_data = '0;
      end else if (dfg_wr) begin
         wr_en   = 1'b1;
         wr_addr = wr_ff[AW-1:0];
         wr_data = rd_data_ff;
      end
   end

   // memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (issue_act) rd_data_ff <= mem[issue_ff[AW-1:0]];
   end

   // result item
   always_comb begin
      rsp_item_in = '0;
      rsp_item_in.status = ST_OK;
      case (op_ff)
         OP_ADD: begin
            if (hit_ff) begin
               rsp_item_in.start_index = START_W'(start_ff);
               rsp_item_in.block_count = COUNT_W'(need_ff);
            end else begin
               rsp_item_in.status = ST_NOSPACE;
            end
         end
         OP_GET: begin
            if (found_ff) begin
               rsp_item_in.start_index = START_W'(start_ff);
               rsp_item_in.block_count = COUNT_W'(count_ff);
            end else begin
               rsp_item_in.status = ST_NOTFOUND;
            end
         end
         default: begin
            rsp_item_in.status = ST_OK;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_busy     = rsp_valid_ff && !rsp_ready;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.load_rsp) rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

@@ hdl/contiguous_block_allocator.sv @@
// top level of the first-fit contiguous block allocator with compaction
//
// channel   direction  handshake             payload
// req_      in         req_valid/req_ready   req_item: operation, descriptor, size_kb
// rsp_      out        rsp_valid/rsp_ready   rsp_item: status, start_index, block_count
//
// one item at a time; get and delete scan the cell memory, add scans it
// for a free run that fits and then fills the run, defragment compacts
// the store during the scan and then clears the tail
// after reset a clearing pass zeroes the store; no item is taken during it
// a stalled result holds in the output register; the next item is taken
// once the previous result has moved into that register
module contiguous_block_allocator #(
   parameter int CELLS = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cba_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cba_pkg::rsp_type rsp_item
);
   import cba_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     rsp_busy;

   // sequencer
   cba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .rsp_busy  (rsp_busy),
      .cmd       (cmd)
   );

   // memory and datapath
   cba_dpath #(
      .CELLS (CELLS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_busy  (rsp_busy),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   // scan and fill never share a cycle
   a_scan_fill_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.scan && cmd.fill))
      else $error("scan and fill active together");

   // an accepted item blocks the input until its work is done
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input ready right after accepting an item");

   // a result is only loaded into a free or draining output register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !(rsp_valid && !rsp_ready))
      else $error("result loaded over a stalled result");

   // no new item is started while a result is being loaded
   a_start_load_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.start && cmd.load_rsp))
      else $error("start and result load together");

endmodule
